@@ rtl/core/bltsw_pkg.sv @@
// shared types and constants for the block-linear tile swizzle
package bltsw_pkg;

  // clamp limits for the configuration registers
  localparam int unsigned MAX_ROW_BYTES = 16384;
  localparam int unsigned MAX_ROWS      = 4096;
  localparam int unsigned MAX_BH_LOG2   = 5;

  // tile geometry
  localparam int unsigned CHUNK_BYTES   = 16;
  localparam int unsigned TILE_W_LOG2   = 6;
  localparam int unsigned TILE_H_LOG2   = 3;
  localparam int unsigned TILE_B_LOG2   = 9;

  // register widths
  localparam int unsigned ROW_BYTES_W   = 15;
  localparam int unsigned FRAME_ROWS_W  = 13;
  localparam int unsigned PITCH_W       = 9;
  localparam int unsigned BH_W          = 3;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_IDX_W     = 3;

  // counter widths
  localparam int unsigned COL_W         = 14;
  localparam int unsigned ROW_W         = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GOBS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BH_LOG2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 3'd4;

  typedef struct packed {
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [63:0]       out_low;
    logic [63:0]       out_high;
    logic [15:0]       byte_enable;
    logic              row_end;
    logic              frame_end;
  } out_item_t;

endpackage

@@ rtl/core/block_linear_tile_swizzle_top.sv @@
// top level of the block-linear tile swizzle: counters, address math, result register
//
// Takes a row-major image as 16-byte chunks, left to right and row by row, and
// returns for each chunk its byte address in a block-linear surface of 64-byte by
// 8-row tiles (16Bx2 order inside a tile), the 16 data bytes unchanged, a byte
// enable mask for a partial last chunk, and row and frame end flags. One result
// per transaction, one transaction per cycle sustained while out_stall_i stays
// low: the address is computed in a single pass (one 9x9 multiply, an add and
// the base add) between the column/row counters and the result register, and
// the input side keeps accepting while the result register is emptied in the
// same cycle. A result is valid in the cycle after its input transaction. Counters
// return to zero after the last chunk of the last row. The user must write the
// plain configuration write port only while idle; the block does not enforce it.
module block_linear_tile_swizzle_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [bltsw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bltsw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // chunk input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bltsw_pkg::in_item_t                 in_data_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bltsw_pkg::out_item_t                out_data_o
);

  // configuration registers
  logic [bltsw_pkg::ROW_BYTES_W-1:0]  row_bytes_q;
  logic [bltsw_pkg::FRAME_ROWS_W-1:0] frame_rows_q;
  logic [bltsw_pkg::PITCH_W-1:0]      pitch_gobs_q;
  logic [bltsw_pkg::BH_W-1:0]         bh_log2_q;
  logic [bltsw_pkg::ADDR_W-1:0]       frame_base_q;

  // running counters
  logic [bltsw_pkg::COL_W-1:0] col_q, col_d;
  logic [bltsw_pkg::ROW_W-1:0] row_q, row_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  bltsw_pkg::out_item_t out_data_q, out_data_d;

  logic in_accept;

  // clamped configuration
  logic [bltsw_pkg::ROW_BYTES_W-1:0]  len;
  logic [bltsw_pkg::FRAME_ROWS_W-1:0] rows;
  logic [bltsw_pkg::BH_W-1:0]         bh;

  // per-chunk decode
  logic [bltsw_pkg::ROW_BYTES_W-1:0] remain;
  logic                              col_past;
  logic [4:0]                        valid_cnt;
  logic [15:0]                       byte_en;
  logic                              rend;
  logic                              fend;

  // address pieces
  logic [7:0]  gob_x;
  logic [8:0]  gob_y;
  logic [8:0]  block_y;
  logic [8:0]  in_block_mask;
  logic [8:0]  in_block;
  logic [17:0] blk_row_prod;
  logic [18:0] blk_sum;
  logic [22:0] blk_sum_sh;
  logic [8:0]  in_tile;
  logic [bltsw_pkg::ADDR_W-1:0] tile_off;

  // transactions flow when the result register is empty or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q  <= 15'd5120;
      frame_rows_q <= 13'd720;
      pitch_gobs_q <= 9'd80;
      bh_log2_q    <= 3'd4;
      frame_base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bltsw_pkg::CFG_ROW_BYTES:  row_bytes_q  <= cfg_data_i[bltsw_pkg::ROW_BYTES_W-1:0];
        bltsw_pkg::CFG_FRAME_ROWS: frame_rows_q <= cfg_data_i[bltsw_pkg::FRAME_ROWS_W-1:0];
        bltsw_pkg::CFG_PITCH_GOBS: pitch_gobs_q <= cfg_data_i[bltsw_pkg::PITCH_W-1:0];
        bltsw_pkg::CFG_BH_LOG2:    bh_log2_q    <= cfg_data_i[bltsw_pkg::BH_W-1:0];
        bltsw_pkg::CFG_FRAME_BASE: frame_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp registers to their legal ranges
  always_comb begin
    len = row_bytes_q;
    if (row_bytes_q == '0) begin
      len = 15'd1;
    end else if (row_bytes_q > 15'(bltsw_pkg::MAX_ROW_BYTES)) begin
      len = 15'(bltsw_pkg::MAX_ROW_BYTES);
    end
    rows = frame_rows_q;
    if (frame_rows_q == '0) begin
      rows = 13'd1;
    end else if (frame_rows_q > 13'(bltsw_pkg::MAX_ROWS)) begin
      rows = 13'(bltsw_pkg::MAX_ROWS);
    end
    bh = bh_log2_q;
    if (bh_log2_q > 3'(bltsw_pkg::MAX_BH_LOG2)) begin
      bh = 3'(bltsw_pkg::MAX_BH_LOG2);
    end
  end

  // byte enables and row/frame end
  always_comb begin
    col_past  = {1'b0, col_q} >= len;
    remain    = len - {1'b0, col_q};
    valid_cnt = '0;
    if (!col_past) begin
      valid_cnt = (remain > 15'(bltsw_pkg::CHUNK_BYTES)) ? 5'(bltsw_pkg::CHUNK_BYTES)
                                                         : remain[4:0];
    end
    byte_en = 16'((17'd1 << valid_cnt) - 17'd1);
    rend    = col_past || (remain <= 15'(bltsw_pkg::CHUNK_BYTES));
    fend    = rend && (({1'b0, row_q} + 13'd1) >= rows);
  end

  // block-linear offset: block row, tile column, tile in block, then 16Bx2 inside
  always_comb begin
    gob_x         = col_q[bltsw_pkg::COL_W-1:bltsw_pkg::TILE_W_LOG2];
    gob_y         = row_q[bltsw_pkg::ROW_W-1:bltsw_pkg::TILE_H_LOG2];
    block_y       = gob_y >> bh;
    in_block_mask = (9'd1 << bh) - 9'd1;
    in_block      = gob_y & in_block_mask;
    blk_row_prod  = block_y * pitch_gobs_q;
    blk_sum       = {1'b0, blk_row_prod} + {11'd0, gob_x};
    blk_sum_sh    = {4'd0, blk_sum} << bh;
    // sector half, row pair, sector, odd row, byte in chunk
    in_tile       = {col_q[5], row_q[2:1], col_q[4], row_q[0], col_q[3:0]};
    tile_off      = {blk_sum_sh | {14'd0, in_block}, in_tile};
  end

  // counter advance and result register load
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (in_accept) begin
      out_valid_d             = 1'b1;
      out_data_d.dest_address = frame_base_q + tile_off;
      out_data_d.out_low      = in_data_i.chunk_low;
      out_data_d.out_high     = in_data_i.chunk_high;
      out_data_d.byte_enable  = byte_en;
      out_data_d.row_end      = rend;
      out_data_d.frame_end    = fend;
      if (!rend) begin
        col_d = col_q + 14'(bltsw_pkg::CHUNK_BYTES);
      end else begin
        col_d = '0;
        row_d = fend ? '0 : row_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // counters restart after the last chunk of a frame
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && fend |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not restart after frame end");

  // only the last chunk of a row can be partial
  a_full_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.row_end |-> out_data_o.byte_enable == 16'hFFFF)
    else $error("partial byte enable on a chunk that does not end its row");

  // frame end always closes a row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.row_end)
    else $error("frame end without row end");

  // column stays chunk aligned
  a_col_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> col_q[3:0] == 4'd0)
    else $error("column counter lost chunk alignment");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the block-linear tile swizzle top level
module tb_top;

  // watchdog: cycles in a row with no transaction on either channel
  localparam int unsigned STALL_LIMIT = 3000;
  // roughly how many random chunks after the directed part
  localparam int unsigned RANDOM_CHUNKS = 300;
  // rows in the one-byte-row frame pass
  localparam int unsigned TALL_ROWS = 72;
  // chunks in that pass, enough to wrap its frame once
  localparam int unsigned TALL_CHUNKS = 80;
  // index with no register behind it, writes there must be ignored
  localparam logic [bltsw_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  // ---------------------------------------------------------------------------
  // address predictor and result checker
  // ---------------------------------------------------------------------------
  class swizzle_scoreboard;
    // mirror of the configuration registers at their real widths
    logic [bltsw_pkg::ROW_BYTES_W-1:0]  row_bytes;
    logic [bltsw_pkg::FRAME_ROWS_W-1:0] frame_rows;
    logic [bltsw_pkg::PITCH_W-1:0]      pitch_gobs;
    logic [bltsw_pkg::BH_W-1:0]         bh_log2;
    logic [bltsw_pkg::ADDR_W-1:0]       frame_base;
    // position of the next chunk in the frame
    logic [bltsw_pkg::COL_W-1:0]        col_byte;
    logic [bltsw_pkg::ROW_W-1:0]        row_idx;

    bltsw_pkg::out_item_t pending_q[$];
    int unsigned          error_count;

    function new();
      row_bytes   = 15'd5120;
      frame_rows  = 13'd720;
      pitch_gobs  = 9'd80;
      bh_log2     = 3'd4;
      frame_base  = '0;
      col_byte    = '0;
      row_idx     = '0;
      error_count = 0;
    endfunction

    function void write_register(logic [bltsw_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bltsw_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bltsw_pkg::CFG_ROW_BYTES:  row_bytes  = val[bltsw_pkg::ROW_BYTES_W-1:0];
        bltsw_pkg::CFG_FRAME_ROWS: frame_rows = val[bltsw_pkg::FRAME_ROWS_W-1:0];
        bltsw_pkg::CFG_PITCH_GOBS: pitch_gobs = val[bltsw_pkg::PITCH_W-1:0];
        bltsw_pkg::CFG_BH_LOG2:    bh_log2    = val[bltsw_pkg::BH_W-1:0];
        bltsw_pkg::CFG_FRAME_BASE: frame_base = val[bltsw_pkg::ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // byte offset of pixel byte (x, y) in the block-linear surface, 16Bx2 order
    function logic [31:0] surface_byte_offset(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] bh);
      logic [31:0] gob_x, gob_y, xin, yin, blk_bytes, off;
      gob_x     = x >> 6;
      gob_y     = y >> 3;
      xin       = x & 32'd63;
      yin       = y & 32'd7;
      blk_bytes = 32'd512 << bh;
      off  = (gob_y >> bh) * {23'd0, pitch_gobs} * blk_bytes;
      off += gob_x * blk_bytes;
      off += (gob_y & ((32'd1 << bh) - 32'd1)) * 32'd512;
      off += (xin >> 5) * 32'd256;
      off += (yin >> 1) * 32'd64;
      off += ((xin & 32'd31) >> 4) * 32'd32;
      off += (yin & 32'd1) * 32'd16;
      off += xin & 32'd15;
      return off;
    endfunction

    // works out the result of one accepted chunk and advances the counters
    function void note_chunk(bltsw_pkg::in_item_t chunk);
      int unsigned          len, rows, bh, col, row, nvalid;
      logic [31:0]          mask;
      bltsw_pkg::out_item_t res;
      len  = row_bytes;
      rows = frame_rows;
      bh   = bh_log2;
      col  = col_byte;
      row  = row_idx;
      // zero or oversized settings are clamped
      if (len == 0) len = 1;
      if (len > bltsw_pkg::MAX_ROW_BYTES) len = bltsw_pkg::MAX_ROW_BYTES;
      if (rows == 0) rows = 1;
      if (rows > bltsw_pkg::MAX_ROWS) rows = bltsw_pkg::MAX_ROWS;
      if (bh > bltsw_pkg::MAX_BH_LOG2) bh = bltsw_pkg::MAX_BH_LOG2;
      nvalid = 0;
      if (col < len) nvalid = (len - col > 16) ? 16 : len - col;
      mask = (32'd1 << nvalid) - 32'd1;
      res.dest_address = frame_base + surface_byte_offset(col, row, bh);
      res.out_low      = chunk.chunk_low;
      res.out_high     = chunk.chunk_high;
      res.byte_enable  = mask[15:0];
      // a column past the row length still ends the row
      res.row_end      = (col >= len) || (len - col <= 16);
      res.frame_end    = res.row_end && (row + 1 >= rows);
      pending_q.push_back(res);
      if (!res.row_end) begin
        col_byte = col_byte + (bltsw_pkg::COL_W)'(16);
      end else begin
        col_byte = '0;
        if (res.frame_end) row_idx = '0;
        else row_idx = row_idx + (bltsw_pkg::ROW_W)'(1);
      end
    endfunction

    function void field_check(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        error_count++;
        $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(bltsw_pkg::out_item_t got);
      bltsw_pkg::out_item_t exp_r;
      if (pending_q.size() == 0) begin
        error_count++;
        $display("%0t unexpected result expected none actual %h", $time, got);
        return;
      end
      exp_r = pending_q.pop_front();
      field_check("dest_address", 64'(exp_r.dest_address), 64'(got.dest_address));
      field_check("out_low", exp_r.out_low, got.out_low);
      field_check("out_high", exp_r.out_high, got.out_high);
      field_check("byte_enable", 64'(exp_r.byte_enable), 64'(got.byte_enable));
      field_check("row_end", 64'(exp_r.row_end), 64'(got.row_end));
      field_check("frame_end", 64'(exp_r.frame_end), 64'(got.frame_end));
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block instance
  // ---------------------------------------------------------------------------
  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [bltsw_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bltsw_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  bltsw_pkg::in_item_t              in_data;
  logic                             out_valid;
  logic                             out_stall;
  bltsw_pkg::out_item_t             out_data;

  // both sides run without gaps while this is set
  bit                               burst_mode;
  swizzle_scoreboard                sb;

  block_linear_tile_swizzle_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // monitor: inputs change only at the rising edge, so the falling edge sees
  // exactly what the next rising edge will accept
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      // note the input first so a pass-through result still finds its entry
      if (in_valid && !in_stall) sb.note_chunk(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: a fresh stall length for every result
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      // wait for a result, it is taken at the next rising edge
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks, all entered and left at a rising edge
  // ---------------------------------------------------------------------------

  // one chunk transaction; valid stays high when the next chunk has no gap
  task automatic send_chunk(bltsw_pkg::in_item_t chunk);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= chunk;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_pattern(logic [63:0] lo, logic [63:0] hi);
    bltsw_pkg::in_item_t c;
    c.chunk_low  = lo;
    c.chunk_high = hi;
    send_chunk(c);
  endtask

  task automatic send_random_chunk();
    bltsw_pkg::in_item_t c;
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = '1;
      default: c = {$urandom(), $urandom(), $urandom(), $urandom()};
    endcase
    send_chunk(c);
  endtask

  // let every expected result drain, then leave the block idle before going on
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write; the scoreboard takes it at the same edge as the block
  task automatic cfg_write(logic [bltsw_pkg::CFG_IDX_W-1:0] idx,
                           logic [bltsw_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_register(idx, val);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  // random bits above the register width half of the time, they must be dropped
  function automatic logic [31:0] with_junk(logic [31:0] val, int unsigned width);
    logic [31:0] junk;
    junk = $urandom() << width;
    if (width >= 32 || $urandom_range(0, 1) == 0) return val;
    return val | junk;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_sent, burst_len, i;
    bit          narrow;

    sb         = new();
    burst_mode = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, data bits all low then all high
    send_pattern(64'h0, 64'h0);
    send_pattern('1, '1);
    settle();

    // column already past a shorter row: empty mask, row ends at once
    cfg_write(bltsw_pkg::CFG_ROW_BYTES, 32'd16);
    cfg_done();
    send_pattern(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_pattern(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    settle();

    // partial last chunk, row already past a shorter frame, zero pitch,
    // block height above the limit and an address that wraps
    cfg_write(bltsw_pkg::CFG_ROW_BYTES, 32'd20);
    cfg_write(bltsw_pkg::CFG_FRAME_ROWS, 32'd2);
    cfg_write(bltsw_pkg::CFG_PITCH_GOBS, 32'd0);
    cfg_write(bltsw_pkg::CFG_BH_LOG2, 32'd7);
    cfg_write(bltsw_pkg::CFG_FRAME_BASE, 32'hffff_fff0);
    cfg_done();
    repeat (6) send_random_chunk();
    settle();

    // zero row length and zero row count clamp to one, unused index ignored
    cfg_write(bltsw_pkg::CFG_ROW_BYTES, 32'd0);
    cfg_write(bltsw_pkg::CFG_FRAME_ROWS, 32'd0);
    cfg_write(CFG_UNUSED_IDX, 32'hffff_ffff);
    cfg_done();
    send_pattern('1, 64'h0);
    send_pattern(64'h0, '1);
    settle();

    // oversized row length and row count clamp to the maximum, widest pitch
    cfg_write(bltsw_pkg::CFG_ROW_BYTES, 32'd32767);
    cfg_write(bltsw_pkg::CFG_FRAME_ROWS, 32'd8191);
    cfg_write(bltsw_pkg::CFG_PITCH_GOBS, 32'd511);
    cfg_write(bltsw_pkg::CFG_BH_LOG2, 32'd5);
    cfg_write(bltsw_pkg::CFG_FRAME_BASE, 32'd0);
    cfg_done();
    send_pattern(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_pattern(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_random_chunk();
    settle();

    // exact maximum sizes, single-tile blocks
    cfg_write(bltsw_pkg::CFG_ROW_BYTES, 32'd16384);
    cfg_write(bltsw_pkg::CFG_FRAME_ROWS, 32'd4096);
    cfg_write(bltsw_pkg::CFG_PITCH_GOBS, 32'd1);
    cfg_write(bltsw_pkg::CFG_BH_LOG2, 32'd0);
    cfg_write(bltsw_pkg::CFG_FRAME_BASE, 32'h8000_0000);
    cfg_done();
    send_random_chunk();
    send_random_chunk();
    settle();

    // random passes: mostly short rows and frames so row and frame ends
    // come often, now and then any register value at all
    random_sent = 0;
    while (random_sent < RANDOM_CHUNKS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      narrow     = ($urandom_range(0, 9) < 8);
      if ($urandom_range(0, 1))
        cfg_write(bltsw_pkg::CFG_ROW_BYTES,
                  with_junk(narrow ? $urandom_range(1, 96) : $urandom_range(0, 32767),
                            bltsw_pkg::ROW_BYTES_W));
      if ($urandom_range(0, 1))
        cfg_write(bltsw_pkg::CFG_FRAME_ROWS,
                  with_junk(narrow ? $urandom_range(1, 6) : $urandom_range(0, 8191),
                            bltsw_pkg::FRAME_ROWS_W));
      if ($urandom_range(0, 1))
        cfg_write(bltsw_pkg::CFG_PITCH_GOBS,
                  with_junk($urandom_range(0, 511), bltsw_pkg::PITCH_W));
      if ($urandom_range(0, 1))
        cfg_write(bltsw_pkg::CFG_BH_LOG2, with_junk($urandom_range(0, 7), bltsw_pkg::BH_W));
      if ($urandom_range(0, 1))
        cfg_write(bltsw_pkg::CFG_FRAME_BASE, $urandom());
      cfg_done();
      burst_len = $urandom_range(4, 40);
      for (i = 0; i < burst_len; i++) send_random_chunk();
      random_sent += burst_len;
      settle();
    end

    // frame of one-byte rows walks the row counter across several tiles (and blocks,
    // for small block heights) and wraps at the last row
    burst_mode = 1'b1;
    cfg_write(bltsw_pkg::CFG_ROW_BYTES, 32'd1);
    cfg_write(bltsw_pkg::CFG_FRAME_ROWS, TALL_ROWS);
    cfg_write(bltsw_pkg::CFG_PITCH_GOBS, $urandom_range(0, 511));
    cfg_write(bltsw_pkg::CFG_BH_LOG2, $urandom_range(0, 5));
    cfg_write(bltsw_pkg::CFG_FRAME_BASE, $urandom());
    cfg_done();
    for (i = 0; i < TALL_CHUNKS; i++) send_random_chunk();
    settle();

    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
